// File: hdl/fat_tree_path_enumerator_top_assert.svh
// Assertion macros for the fat tree path enumerator checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef FAT_TREE_PATH_ENUMERATOR_TOP_ASSERT_SVH
`define FAT_TREE_PATH_ENUMERATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftpe same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FTPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftpe next-cycle check failed");

`endif

// File: hdl/ftpe_pkg.sv
// Shared types, constants and helper functions for the fat tree path enumerator.
// No dependencies; used by the controller, datapath and top level.
package ftpe_pkg;

  localparam int MAX_HALF_PORTS = 8;
  localparam int HOST_W  = 10;
  localparam int FLOW_W  = 20;
  localparam int SPLIT_W = 32;
  localparam int QUEUE_W = 13;

  localparam logic [1:0] KIND_EDGE = 2'd0;
  localparam logic [1:0] KIND_POD  = 2'd1;
  localparam logic [1:0] KIND_CORE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_POD,
    ST_DIV_LOC,
    ST_SETUP1,
    ST_SETUP2,
    ST_EMIT
  } ftpe_state_t;

  typedef struct packed {
    logic load;
    logic sub_pod;
    logic sub_loc;
    logic setup1;
    logic setup2;
    logic advance;
  } ftpe_cmd_t;

  typedef struct packed {
    logic bad_input;
    logic pod_done;
    logic loc_done;
    logic last;
  } ftpe_status_t;

  // Clamp the register value into the supported range.
  function automatic logic [3:0] eff_half(input logic [3:0] raw);
    logic [3:0] h;
    h = raw;
    if (h < 4'd2) h = 4'd2;
    if (h > 4'(MAX_HALF_PORTS)) h = 4'(MAX_HALF_PORTS);
    return h;
  endfunction

  // h^3 for the clamped h.
  function automatic logic [9:0] half_cube(input logic [3:0] h);
    logic [9:0] c;
    case (h)
      4'd2:    c = 10'd8;
      4'd3:    c = 10'd27;
      4'd4:    c = 10'd64;
      4'd5:    c = 10'd125;
      4'd6:    c = 10'd216;
      4'd7:    c = 10'd343;
      4'd8:    c = 10'd512;
      default: c = 10'd8;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/ftpe_ctrl.sv
// Sequencer for the path enumerator: divide, set up, then emit one path per cycle unless out_stall holds it.
// Depends on ftpe_pkg; drives commands into ftpe_dpath.
module ftpe_ctrl import ftpe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  ftpe_status_t status,
  output ftpe_cmd_t    cmd
);

  ftpe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = status.bad_input ? ST_IDLE : ST_DIV_POD;
      end
      ST_DIV_POD: begin
        if (status.pod_done) state_nxt = ST_DIV_LOC;
      end
      ST_DIV_LOC: begin
        if (status.loc_done) state_nxt = ST_SETUP1;
      end
      ST_SETUP1: state_nxt = ST_SETUP2;
      ST_SETUP2: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_stall && status.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV_POD: cmd.sub_pod = 1'b1;
      ST_DIV_LOC: cmd.sub_loc = 1'b1;
      ST_SETUP1:  cmd.setup1 = 1'b1;
      ST_SETUP2:  cmd.setup2 = 1'b1;
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = !out_stall;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/ftpe_dpath.sv
// Datapath: host split by repeated subtraction, queue id setup and per-path stepping.
// Depends on ftpe_pkg; commanded by ftpe_ctrl.
module ftpe_dpath import ftpe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_half_ports,
  input  logic [HOST_W-1:0]   in_client_host,
  input  logic [HOST_W-1:0]   in_server_host,
  input  ftpe_cmd_t           cmd,
  output ftpe_status_t        status,
  output logic [FLOW_W-1:0]   out_flow_index,
  output logic [SPLIT_W-1:0]  out_split_index,
  output logic [1:0]          out_path_kind,
  output logic [QUEUE_W-1:0]  out_host_up_queue,
  output logic [QUEUE_W-1:0]  out_edge_up_queue,
  output logic [QUEUE_W-1:0]  out_aggr_up_queue,
  output logic [QUEUE_W-1:0]  out_core_down_queue,
  output logic [QUEUE_W-1:0]  out_aggr_down_queue,
  output logic [QUEUE_W-1:0]  out_edge_down_queue,
  output logic                out_last_path
);

  logic [3:0]  half_ports_r;
  logic [31:0] split_r;

  logic [3:0]         h;
  logic [2:0]         hm1;
  logic [QUEUE_W-1:0] kq;      // K = 2h
  logic [QUEUE_W-1:0] hq;
  logic [9:0]         hh;
  logic [9:0]         h3;
  logic [10:0]        hosts;
  logic [QUEUE_W-1:0] aggr_base, edge_base, host_base;

  logic [HOST_W-1:0] cl_r, cl_nxt, sv_r, sv_nxt, rc_r, rc_nxt, rs_r, rs_nxt;
  logic [3:0]        pc_r, pc_nxt, ps_r, ps_nxt;
  logic [2:0]        ecl_r, ecl_nxt, js_r, js_nxt;
  logic [6:0]        pch_r, pch_nxt, psh_r, psh_nxt, ec_r, ec_nxt, es_r, es_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [2:0]        k_r, k_nxt, m_r, m_nxt;
  logic [QUEUE_W-1:0] s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  logic [QUEUE_W-1:0] s4_r, s4_nxt, s5_r, s5_nxt, b2_r, b2_nxt;

  logic [20:0]       flow_prod;
  logic [HOST_W-1:0] rank;
  logic              k_end, m_end;

  assign h         = eff_half(half_ports_r);
  assign hm1       = 3'(h - 4'd1);
  assign kq        = QUEUE_W'({h, 1'b0});
  assign hq        = QUEUE_W'(h);
  assign hh        = 10'(h * h);
  assign h3        = half_cube(h);
  assign hosts     = {h3, 1'b0};
  assign aggr_base = QUEUE_W'(h3) * QUEUE_W'(2);
  assign edge_base = QUEUE_W'(h3) * QUEUE_W'(6);
  assign host_base = QUEUE_W'(h3) * QUEUE_W'(10);

  assign status.bad_input = (in_client_host == in_server_host)
                         || (11'(in_client_host) >= hosts)
                         || (11'(in_server_host) >= hosts);
  assign status.pod_done  = (rc_r < hh) && (rs_r < hh);
  assign status.loc_done  = (rc_r < 10'(h)) && (rs_r < 10'(h));

  assign k_end = (k_r == hm1);
  assign m_end = (m_r == hm1);
  assign status.last = (kind_r == KIND_EDGE) ? 1'b1
                     : (kind_r == KIND_POD)  ? k_end
                     : (k_end && m_end);

  assign flow_prod = 21'(cl_r) * 21'(hosts - 11'd1);
  assign rank      = (sv_r < cl_r) ? sv_r : sv_r - 10'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_ports_r <= 4'd2;
      split_r      <= '0;
    end else begin
      if (cfg_we) half_ports_r <= cfg_half_ports;
      if (cmd.advance) split_r <= split_r + 32'd1;
    end
  end

  always_comb begin
    cl_nxt = cl_r;  sv_nxt = sv_r;  rc_nxt = rc_r;  rs_nxt = rs_r;
    pc_nxt = pc_r;  ps_nxt = ps_r;  ecl_nxt = ecl_r; js_nxt = js_r;
    pch_nxt = pch_r; psh_nxt = psh_r; ec_nxt = ec_r; es_nxt = es_r;
    flow_nxt = flow_r; kind_nxt = kind_r; k_nxt = k_r; m_nxt = m_r;
    s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r; s3_nxt = s3_r;
    s4_nxt = s4_r; s5_nxt = s5_r; b2_nxt = b2_r;

    if (cmd.load) begin
      cl_nxt  = in_client_host;
      sv_nxt  = in_server_host;
      rc_nxt  = in_client_host;
      rs_nxt  = in_server_host;
      pc_nxt  = '0;
      ps_nxt  = '0;
      ecl_nxt = '0;
      js_nxt  = '0;
    end

    // pod = host / h^2, one subtraction per cycle
    if (cmd.sub_pod) begin
      if (rc_r >= hh) begin
        rc_nxt = rc_r - hh;
        pc_nxt = pc_r + 4'd1;
      end
      if (rs_r >= hh) begin
        rs_nxt = rs_r - hh;
        ps_nxt = ps_r + 4'd1;
      end
    end

    // edge within pod = local / h; remainder is the host port
    if (cmd.sub_loc) begin
      if (rc_r >= 10'(h)) begin
        rc_nxt  = rc_r - 10'(h);
        ecl_nxt = ecl_r + 3'd1;
      end
      if (rs_r >= 10'(h)) begin
        rs_nxt = rs_r - 10'(h);
        js_nxt = js_r + 3'd1;
      end
    end

    if (cmd.setup1) begin
      pch_nxt  = 7'(pc_r * h);
      psh_nxt  = 7'(ps_r * h);
      ec_nxt   = 7'(pc_r * h) + 7'(ecl_r);
      es_nxt   = 7'(ps_r * h) + 7'(js_r);
      flow_nxt = flow_prod[FLOW_W-1:0] + FLOW_W'(rank);
    end

    if (cmd.setup2) begin
      if (ec_r == es_r)      kind_nxt = KIND_EDGE;
      else if (pc_r == ps_r) kind_nxt = KIND_POD;
      else                   kind_nxt = KIND_CORE;
      s0_nxt = host_base + QUEUE_W'(cl_r);
      s1_nxt = edge_base + QUEUE_W'(ec_r) * kq;
      s5_nxt = edge_base + QUEUE_W'(es_r) * kq + hq + QUEUE_W'(rs_r);
      s4_nxt = aggr_base + QUEUE_W'((pc_r == ps_r) ? pch_r : psh_r) * kq + hq
             + QUEUE_W'(js_r);
      b2_nxt = aggr_base + QUEUE_W'(pch_r) * kq;
      s2_nxt = aggr_base + QUEUE_W'(pch_r) * kq;
      s3_nxt = QUEUE_W'(ps_r);
      k_nxt  = '0;
      m_nxt  = '0;
    end

    if (cmd.advance) begin
      if (kind_r == KIND_CORE) begin
        s3_nxt = s3_r + kq;     // core index k*h+m steps by one per path
        if (m_end) begin
          m_nxt  = '0;
          k_nxt  = k_r + 3'd1;
          b2_nxt = b2_r + kq;
          s2_nxt = b2_r + kq;
          s1_nxt = s1_r + QUEUE_W'(1);
          s4_nxt = s4_r + kq;
        end else begin
          m_nxt  = m_r + 3'd1;
          s2_nxt = s2_r + QUEUE_W'(1);
        end
      end else begin
        k_nxt  = k_r + 3'd1;
        s1_nxt = s1_r + QUEUE_W'(1);
        s4_nxt = s4_r + kq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_EDGE;
      k_r    <= '0;
      m_r    <= '0;
    end else begin
      kind_r <= kind_nxt;
      k_r    <= k_nxt;
      m_r    <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cl_r <= cl_nxt;  sv_r <= sv_nxt;  rc_r <= rc_nxt;  rs_r <= rs_nxt;
    pc_r <= pc_nxt;  ps_r <= ps_nxt;  ecl_r <= ecl_nxt; js_r <= js_nxt;
    pch_r <= pch_nxt; psh_r <= psh_nxt; ec_r <= ec_nxt; es_r <= es_nxt;
    flow_r <= flow_nxt;
    s0_r <= s0_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt; s3_r <= s3_nxt;
    s4_r <= s4_nxt; s5_r <= s5_nxt; b2_r <= b2_nxt;
  end

  assign out_flow_index      = flow_r;
  assign out_split_index     = split_r;
  assign out_path_kind       = kind_r;
  assign out_host_up_queue   = s0_r;
  assign out_edge_up_queue   = (kind_r == KIND_EDGE) ? '0 : s1_r;
  assign out_aggr_up_queue   = (kind_r == KIND_CORE) ? s2_r : '0;
  assign out_core_down_queue = (kind_r == KIND_CORE) ? s3_r : '0;
  assign out_aggr_down_queue = (kind_r == KIND_EDGE) ? '0 : s4_r;
  assign out_edge_down_queue = s5_r;
  assign out_last_path       = status.last;

endmodule

// File: hdl/fat_tree_path_enumerator_top.sv
// Fat tree ECMP path enumerator, top level. One host pair at a time.
// Sequence: accept, pod split by repeated subtraction, edge split, setup (SETUP1, SETUP2),
// then one path per cycle while out_stall is low: 1, h or h*h paths (up to 64 at h=8).
// Next pair is taken the cycle after the last path is delivered.
// Synchronous active-low reset: sequencer idle, split counter 0, half_ports 2.
module fat_tree_path_enumerator_top import ftpe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_half_ports,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [HOST_W-1:0]   in_client_host,
  input  logic [HOST_W-1:0]   in_server_host,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FLOW_W-1:0]   out_flow_index,
  output logic [SPLIT_W-1:0]  out_split_index,
  output logic [1:0]          out_path_kind,
  output logic [QUEUE_W-1:0]  out_host_up_queue,
  output logic [QUEUE_W-1:0]  out_edge_up_queue,
  output logic [QUEUE_W-1:0]  out_aggr_up_queue,
  output logic [QUEUE_W-1:0]  out_core_down_queue,
  output logic [QUEUE_W-1:0]  out_aggr_down_queue,
  output logic [QUEUE_W-1:0]  out_edge_down_queue,
  output logic                out_last_path
);

  ftpe_cmd_t    cmd;
  ftpe_status_t status;

  ftpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ftpe_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_half_ports      (cfg_half_ports),
    .in_client_host      (in_client_host),
    .in_server_host      (in_server_host),
    .cmd                 (cmd),
    .status              (status),
    .out_flow_index      (out_flow_index),
    .out_split_index     (out_split_index),
    .out_path_kind       (out_path_kind),
    .out_host_up_queue   (out_host_up_queue),
    .out_edge_up_queue   (out_edge_up_queue),
    .out_aggr_up_queue   (out_aggr_up_queue),
    .out_core_down_queue (out_core_down_queue),
    .out_aggr_down_queue (out_aggr_down_queue),
    .out_edge_down_queue (out_edge_down_queue),
    .out_last_path       (out_last_path)
  );

endmodule

// File: hdl/ftpe_checker.sv
// Port-level checks for the fat tree path enumerator, bound to the top level.
// Depends on ftpe_pkg and fat_tree_path_enumerator_top_assert.svh.
`include "fat_tree_path_enumerator_top_assert.svh"

module ftpe_checker import ftpe_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [SPLIT_W-1:0] out_split_index,
  input logic [1:0]         out_path_kind
);

  // one pair in flight: no new transaction while paths are pending
  `FTPE_ASSERT_NOW(a_busy_while_emitting, out_valid, in_stall)
  // no path shows right after an accept: the split and setup states come first
  `FTPE_ASSERT_NEXT(a_no_path_right_after_accept, in_valid && !in_stall, !out_valid)
  // split counter steps by exactly one per delivered path
  `FTPE_ASSERT_NEXT(a_split_steps, out_valid && !out_stall, out_split_index == $past(out_split_index) + 32'd1)
  `FTPE_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_split_index) && $stable(out_path_kind))

endmodule

bind fat_tree_path_enumerator_top ftpe_checker u_ftpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_split_index (out_split_index),
  .out_path_kind   (out_path_kind)
);

// File: verif/fat_tree_path_enumerator_checker.sv
// Checker for the fat tree path enumerator: watches the config, input and result channels,
// predicts every path of each accepted host pair and compares field by field.
// Depends on ftpe_pkg for field widths.
module fat_tree_path_enumerator_checker import ftpe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_half_ports,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [HOST_W-1:0]  in_client_host,
  input  logic [HOST_W-1:0]  in_server_host,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [FLOW_W-1:0]  out_flow_index,
  input  logic [SPLIT_W-1:0] out_split_index,
  input  logic [1:0]         out_path_kind,
  input  logic [QUEUE_W-1:0] out_host_up_queue,
  input  logic [QUEUE_W-1:0] out_edge_up_queue,
  input  logic [QUEUE_W-1:0] out_aggr_up_queue,
  input  logic [QUEUE_W-1:0] out_core_down_queue,
  input  logic [QUEUE_W-1:0] out_aggr_down_queue,
  input  logic [QUEUE_W-1:0] out_edge_down_queue,
  input  logic               out_last_path,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [FLOW_W-1:0]  flow_index;
    logic [SPLIT_W-1:0] split_index;
    logic [1:0]         path_kind;
    logic [QUEUE_W-1:0] stage0_q;
    logic [QUEUE_W-1:0] stage1_q;
    logic [QUEUE_W-1:0] stage2_q;
    logic [QUEUE_W-1:0] stage3_q;
    logic [QUEUE_W-1:0] stage4_q;
    logic [QUEUE_W-1:0] stage5_q;
    logic               last_path;
  } ecmp_path_t;

  ecmp_path_t         pending_paths[$];
  logic [SPLIT_W-1:0] path_count;
  logic [3:0]         half_reg;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    path_count  = '0;
    half_reg    = 4'd2;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic push_path(input int unsigned flow, input logic [1:0] kind,
                           input int unsigned s0, input int unsigned s1,
                           input int unsigned s2, input int unsigned s3,
                           input int unsigned s4, input int unsigned s5,
                           input bit last);
    ecmp_path_t p;
    p.flow_index  = FLOW_W'(flow);
    p.split_index = path_count;
    p.path_kind   = kind;
    p.stage0_q    = QUEUE_W'(s0);
    p.stage1_q    = QUEUE_W'(s1);
    p.stage2_q    = QUEUE_W'(s2);
    p.stage3_q    = QUEUE_W'(s3);
    p.stage4_q    = QUEUE_W'(s4);
    p.stage5_q    = QUEUE_W'(s5);
    p.last_path   = last;
    pending_paths.insert(pending_paths.size(), p);
    path_count = path_count + 32'd1;
  endtask

  // Expands one host pair into its equal-cost paths.
  task automatic enumerate_paths(input logic [HOST_W-1:0] client,
                                 input logic [HOST_W-1:0] server);
    int unsigned h, ports, hpp, hosts, aggr_base, edge_base, host_base;
    int unsigned cl, sv, pc, ps, ec, es, js, flow, s0, s1, s2, s3, s4, s5;
    h = half_reg;
    if (h < 2) h = 2;
    if (h > MAX_HALF_PORTS) h = MAX_HALF_PORTS;
    ports = 2 * h;
    hpp   = h * h;
    hosts = 2 * h * hpp;
    cl    = client;
    sv    = server;
    if (cl == sv || cl >= hosts || sv >= hosts) return;
    aggr_base = hpp * ports;
    edge_base = aggr_base + 2 * hpp * ports;
    host_base = edge_base + 2 * hpp * ports;
    pc   = cl / hpp;
    ps   = sv / hpp;
    ec   = pc * h + (cl % hpp) / h;
    js   = (sv % hpp) / h;
    es   = ps * h + js;
    flow = cl * (hosts - 1) + ((sv < cl) ? sv : sv - 1);
    s0   = host_base + cl;
    s5   = edge_base + es * ports + h + (sv % hpp) % h;
    if (ec == es) begin
      push_path(flow, KIND_EDGE, s0, 0, 0, 0, 0, s5, 1'b1);
    end else if (pc == ps) begin
      for (int unsigned k = 0; k < h; k++) begin
        s1 = edge_base + ec * ports + k;
        s4 = aggr_base + (pc * h + k) * ports + h + js;
        push_path(flow, KIND_POD, s0, s1, 0, 0, s4, s5, k + 1 == h);
      end
    end else begin
      for (int unsigned k = 0; k < h; k++) begin
        s1 = edge_base + ec * ports + k;
        s4 = aggr_base + (ps * h + k) * ports + h + js;
        for (int unsigned m = 0; m < h; m++) begin
          s2 = aggr_base + (pc * h + k) * ports + m;
          s3 = (k * h + m) * ports + ps;
          push_path(flow, KIND_CORE, s0, s1, s2, s3, s4, s5, k + 1 == h && m + 1 == h);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    ecmp_path_t want;
    if (!rst_n) begin
      pending_paths.delete();
      path_count = '0;
      half_reg   = 4'd2;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_paths.size() == 0) begin
          report_mismatch("result transaction with no path expected", out_split_index, 0);
        end else begin
          want = pending_paths.pop_front();
          check_field("split_index", out_split_index, want.split_index);
          check_field("flow_index", 32'(out_flow_index), 32'(want.flow_index));
          check_field("path_kind", 32'(out_path_kind), 32'(want.path_kind));
          check_field("stage 0 queue", 32'(out_host_up_queue), 32'(want.stage0_q));
          check_field("stage 1 queue", 32'(out_edge_up_queue), 32'(want.stage1_q));
          check_field("stage 2 queue", 32'(out_aggr_up_queue), 32'(want.stage2_q));
          check_field("stage 3 queue", 32'(out_core_down_queue), 32'(want.stage3_q));
          check_field("stage 4 queue", 32'(out_aggr_down_queue), 32'(want.stage4_q));
          check_field("stage 5 queue", 32'(out_edge_down_queue), 32'(want.stage5_q));
          check_field("last_path", 32'(out_last_path), 32'(want.last_path));
        end
      end
      if (in_valid && !in_stall) enumerate_paths(in_client_host, in_server_host);
      if (cfg_we) half_reg = cfg_half_ports;
    end
    outstanding <= pending_paths.size();
  end

endmodule

// File: verif/fat_tree_path_enumerator_top_tb.sv
// Testbench top for the fat tree path enumerator: clock, reset, host pair stimulus,
// half_ports settings and receiver stalls. Checking lives in fat_tree_path_enumerator_checker.
module fat_tree_path_enumerator_top_tb import ftpe_pkg::*; ();

  localparam int CLK_HALF       = 6;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_SET  = 13;
  localparam int TIMEOUT_CYCLES = 600000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [3:0]         cfg_half_ports;
  logic               in_valid;
  logic               in_stall;
  logic [HOST_W-1:0]  in_client_host;
  logic [HOST_W-1:0]  in_server_host;
  logic               out_valid;
  logic               out_stall;
  logic [FLOW_W-1:0]  out_flow_index;
  logic [SPLIT_W-1:0] out_split_index;
  logic [1:0]         out_path_kind;
  logic [QUEUE_W-1:0] out_host_up_queue;
  logic [QUEUE_W-1:0] out_edge_up_queue;
  logic [QUEUE_W-1:0] out_aggr_up_queue;
  logic [QUEUE_W-1:0] out_core_down_queue;
  logic [QUEUE_W-1:0] out_aggr_down_queue;
  logic [QUEUE_W-1:0] out_edge_down_queue;
  logic               out_last_path;

  int          mismatches;
  int          outstanding;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned active_half;
  int          hold_token;

  fat_tree_path_enumerator_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_half_ports      (cfg_half_ports),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_client_host      (in_client_host),
    .in_server_host      (in_server_host),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flow_index      (out_flow_index),
    .out_split_index     (out_split_index),
    .out_path_kind       (out_path_kind),
    .out_host_up_queue   (out_host_up_queue),
    .out_edge_up_queue   (out_edge_up_queue),
    .out_aggr_up_queue   (out_aggr_up_queue),
    .out_core_down_queue (out_core_down_queue),
    .out_aggr_down_queue (out_aggr_down_queue),
    .out_edge_down_queue (out_edge_down_queue),
    .out_last_path       (out_last_path)
  );

  fat_tree_path_enumerator_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_half_ports      (cfg_half_ports),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_client_host      (in_client_host),
    .in_server_host      (in_server_host),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_flow_index      (out_flow_index),
    .out_split_index     (out_split_index),
    .out_path_kind       (out_path_kind),
    .out_host_up_queue   (out_host_up_queue),
    .out_edge_up_queue   (out_edge_up_queue),
    .out_aggr_up_queue   (out_aggr_up_queue),
    .out_core_down_queue (out_core_down_queue),
    .out_aggr_down_queue (out_aggr_down_queue),
    .out_edge_down_queue (out_edge_down_queue),
    .out_last_path       (out_last_path),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off per request token.
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // One input transaction; returns at the edge where it is accepted.
  task automatic send_pair(input logic [HOST_W-1:0] client, input logic [HOST_W-1:0] server);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_client_host <= client;
    in_server_host <= server;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every expected path, then let no-result pairs drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half(input logic [3:0] value);
    settle();
    cfg_we         <= 1'b1;
    cfg_half_ports <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_half = (value < 2) ? 2 : (value > MAX_HALF_PORTS) ? MAX_HALF_PORTS : value;
  endtask

  // Mostly well-formed pairs of each path class, some same-host and raw noise.
  task automatic pick_pair(output logic [HOST_W-1:0] client, output logic [HOST_W-1:0] server);
    int unsigned h, hpp, pods, sel, pod_c, edge_c, pick;
    h      = active_half;
    hpp    = h * h;
    pods   = 2 * h;
    sel    = $urandom_range(99);
    client = HOST_W'($urandom_range(pods * hpp - 1));
    pod_c  = client / hpp;
    edge_c = (client % hpp) / h;
    if (sel < 8) begin
      client = HOST_W'($urandom);
      server = HOST_W'($urandom);
    end else if (sel < 12) begin
      server = client;
    end else if (sel < 40) begin
      pick   = (client % h + 1 + $urandom_range(h - 2)) % h;
      server = HOST_W'(client - client % h + pick);
    end else if (sel < 65) begin
      pick   = (edge_c + 1 + $urandom_range(h - 2)) % h;
      server = HOST_W'(pod_c * hpp + pick * h + $urandom_range(h - 1));
    end else begin
      pick   = (pod_c + 1 + $urandom_range(pods - 2)) % pods;
      server = HOST_W'(pick * hpp + $urandom_range(hpp - 1));
    end
  endtask

  initial begin
    logic [3:0]        half_plan[12];
    logic [HOST_W-1:0] client;
    logic [HOST_W-1:0] server;
    half_plan      = '{4'd3, 4'd1, 4'd9, 4'd5, 4'd15, 4'd4, 4'd2, 4'd6, 4'd0, 4'd7, 4'd8, 4'd12};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_half_ports = 4'd0;
    in_valid       = 1'b0;
    in_client_host = '0;
    in_server_host = '0;
    send_idle_pct  = 19;
    recv_idle_pct  = 66;
    active_half    = 2;
    hold_token     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value h=2: 16 hosts, every path class, same host, out of range.
    send_pair(10'd0, 10'd1);
    send_pair(10'd0, 10'd2);
    send_pair(10'd0, 10'd15);
    send_pair(10'd15, 10'd0);
    send_pair(10'd5, 10'd5);
    send_pair(10'd16, 10'd0);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1023, 10'd1023);

    // Register above range clamps to the largest tree.
    write_half(4'd15);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd1023, 10'd1022);
    send_pair(10'd0, 10'd8);
    send_pair(10'd512, 10'd511);
    send_pair(10'd1023, 10'd1023);

    // Register below range acts as h=2.
    write_half(4'd0);
    send_pair(10'd3, 10'd12);
    send_pair(10'd7, 10'd4);
    send_pair(10'd6, 10'd6);

    for (int set = 0; set < 12; set++) begin
      write_half(half_plan[set]);
      if (set < 4) begin
        send_idle_pct = 19;
        recv_idle_pct = 66;
      end else if (set < 8) begin
        send_idle_pct = 66;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (set == 4) begin
        // Long receiver hold-off with the largest tree so the input backs up.
        hold_token++;
        for (int i = 0; i < 6; i++) send_pair(HOST_W'(100 + i), HOST_W'(900 - i));
      end
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        pick_pair(client, server);
        send_pair(client, server);
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
